FILE: hdl/hysteresis_switch_with_daily_runtime_macros.svh
// Assertion macros for the hysteresis switch with daily runtime.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef HYSTERESIS_SWITCH_WITH_DAILY_RUNTIME_MACROS_SVH
`define HYSTERESIS_SWITCH_WITH_DAILY_RUNTIME_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define HSWDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, also during reset.
`define HSWDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/hswdr_pkg.sv
// Shared types, constants and the level compare function for the
// hysteresis switch with daily runtime. No dependencies.
`default_nettype none

package hswdr_pkg;

  localparam int unsigned RtW   = 37;
  localparam int unsigned TsW   = 63;
  localparam int unsigned CntW  = 16;
  localparam int unsigned DayW  = 5;
  localparam int unsigned HourW = 5;
  localparam int unsigned ValW  = 32;
  localparam int unsigned IdxW  = 3;

  localparam logic [RtW-1:0]  RtMax  = {RtW{1'b1}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef enum logic [1:0] {
    CMP_GE    = 2'd0,
    CMP_LE    = 2'd1,
    CMP_NEVER = 2'd2
  } cmp_e;

  typedef enum logic [IdxW-1:0] {
    REG_ON_THRESHOLD  = 3'd0,
    REG_ON_COMPARE    = 3'd1,
    REG_OFF_THRESHOLD = 3'd2,
    REG_OFF_COMPARE   = 3'd3,
    REG_WARMUP_COUNT  = 3'd4,
    REG_MIN_RUNTIME   = 3'd5,
    REG_HOUR_BORDER   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [ValW-1:0] on_threshold;
    logic [1:0]             on_compare;
    logic signed [ValW-1:0] off_threshold;
    logic [1:0]             off_compare;
    logic [CntW-1:0]        warmup_count;
    logic [RtW-1:0]         min_runtime;
    logic [HourW-1:0]       hour_border;
  } cfg_t;

  typedef struct packed {
    logic signed [ValW-1:0] sample_value;
    logic [TsW-1:0]         timestamp_us;
    logic [DayW-1:0]        day_of_month;
    logic [HourW-1:0]       hour_of_day;
  } item_t;

  typedef struct packed {
    logic           switch_on;
    logic           turned_on;
    logic           turned_off;
    logic           by_timer;
    logic [RtW-1:0] runtime_today_us;
  } res_t;

  function automatic logic level_test(logic signed [ValW-1:0] sample,
                                      logic signed [ValW-1:0] level,
                                      logic [1:0] kind);
    logic hit;
    hit = 1'b0;
    case (kind)
      CMP_GE:  hit = (sample >= level);
      CMP_LE:  hit = (sample <= level);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hswdr_cfg.sv
// Configuration register file of the hysteresis switch.
// Depends on hswdr_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module hswdr_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hswdr_pkg::IdxW-1:0]    cfg_index_i,
  input  wire logic [hswdr_pkg::RtW-1:0]     cfg_wdata_i,
  output hswdr_pkg::cfg_t                    cfg_o
);

  hswdr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        hswdr_pkg::REG_ON_THRESHOLD:  cfg_d.on_threshold  = cfg_wdata_i[31:0];
        hswdr_pkg::REG_ON_COMPARE:    cfg_d.on_compare    = cfg_wdata_i[1:0];
        hswdr_pkg::REG_OFF_THRESHOLD: cfg_d.off_threshold = cfg_wdata_i[31:0];
        hswdr_pkg::REG_OFF_COMPARE:   cfg_d.off_compare   = cfg_wdata_i[1:0];
        hswdr_pkg::REG_WARMUP_COUNT:  cfg_d.warmup_count  = cfg_wdata_i[15:0];
        hswdr_pkg::REG_MIN_RUNTIME:   cfg_d.min_runtime   = cfg_wdata_i;
        hswdr_pkg::REG_HOUR_BORDER:   cfg_d.hour_border   = cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_threshold  <= '0;
      cfg_q.on_compare    <= hswdr_pkg::CMP_NEVER;
      cfg_q.off_threshold <= '0;
      cfg_q.off_compare   <= hswdr_pkg::CMP_NEVER;
      cfg_q.warmup_count  <= '0;
      cfg_q.min_runtime   <= '0;
      cfg_q.hour_border   <= 5'd24;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/hswdr_core.sv
// Switch state and per-sample decision logic of the hysteresis switch.
// Depends on hswdr_pkg for cfg_t, item_t, res_t and level_test.
`default_nettype none

module hswdr_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hswdr_pkg::cfg_t  cfg_i,
  input  wire hswdr_pkg::item_t item_i,
  input  wire logic             fire_i,
  output hswdr_pkg::res_t       res_o
);

  logic                          is_on_q, is_on_d;
  logic [hswdr_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [hswdr_pkg::RtW-1:0]     rt_q, rt_d;
  logic [hswdr_pkg::DayW-1:0]    day_q;
  logic [hswdr_pkg::TsW-1:0]     since_q, since_d;

  logic [hswdr_pkg::RtW-1:0]     rt_base;
  logic [hswdr_pkg::TsW-1:0]     diff;
  logic [hswdr_pkg::RtW:0]       sum;
  logic                          sat;
  logic                          active;
  logic                          timer;
  logic                          on_hit;
  logic                          off_hit;
  logic                          t_on;
  logic                          t_off;
  logic                          t_timer;

  always_comb begin
    cnt_d   = (cnt_q == hswdr_pkg::CntMax) ? cnt_q : cnt_q + 1'b1;
    active  = (cnt_d >= cfg_i.warmup_count);
    rt_base = (item_i.day_of_month != day_q) ? '0 : rt_q;
    diff    = (item_i.timestamp_us >= since_q) ? item_i.timestamp_us - since_q : '0;
    sum     = {1'b0, rt_base} + {1'b0, diff[hswdr_pkg::RtW-1:0]};
    sat     = (|diff[hswdr_pkg::TsW-1:hswdr_pkg::RtW]) || sum[hswdr_pkg::RtW];
    rt_d    = rt_base;
    if (active && is_on_q) begin
      rt_d = sat ? hswdr_pkg::RtMax : sum[hswdr_pkg::RtW-1:0];
    end
    timer   = (item_i.hour_of_day >= cfg_i.hour_border) && (rt_d < cfg_i.min_runtime);
    on_hit  = hswdr_pkg::level_test(item_i.sample_value, cfg_i.on_threshold,
                                    cfg_i.on_compare);
    off_hit = hswdr_pkg::level_test(item_i.sample_value, cfg_i.off_threshold,
                                    cfg_i.off_compare);
    t_on    = 1'b0;
    t_off   = 1'b0;
    t_timer = 1'b0;
    if (active) begin
      if (!is_on_q && on_hit) begin
        t_on = 1'b1;
      end else if (is_on_q && off_hit && !timer) begin
        t_off = 1'b1;
      end else if (!is_on_q && timer) begin
        t_on    = 1'b1;
        t_timer = 1'b1;
      end
    end
    is_on_d = (is_on_q || t_on) && !t_off;
    since_d = (active && (is_on_q || t_on)) ? item_i.timestamp_us : since_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_on_q <= 1'b0;
      cnt_q   <= '0;
      rt_q    <= '0;
      day_q   <= '0;
      since_q <= '0;
    end else if (fire_i) begin
      is_on_q <= is_on_d;
      cnt_q   <= cnt_d;
      rt_q    <= rt_d;
      day_q   <= item_i.day_of_month;
      since_q <= since_d;
    end
  end

  assign res_o.switch_on        = is_on_d;
  assign res_o.turned_on        = t_on;
  assign res_o.turned_off       = t_off;
  assign res_o.by_timer         = t_timer;
  assign res_o.runtime_today_us = rt_d;

endmodule

`default_nettype wire

FILE: hdl/hysteresis_switch_with_daily_runtime.sv
// Top level of the hysteresis switch with daily runtime: input register,
// result register and handshakes. Depends on hswdr_pkg, hswdr_cfg, hswdr_core.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    sample, timestamp, day, hour
// out      output     out_valid_o / out_stall_i  switch flags, runtime today
// cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A transaction is taken into the input register, decided from there
// and its result is registered; one item per cycle while the output does not stall.
// The state update and the result load happen at the same edge, so the rate
// is set by the single decision path between these two registers.
// Reset clears the switch state and loads the register defaults at once.
// A stall on the output holds the result and backs up into in_stall_o.
`default_nettype none
`include "hysteresis_switch_with_daily_runtime_macros.svh"

module hysteresis_switch_with_daily_runtime (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [hswdr_pkg::IdxW-1:0]        cfg_index_i,
  input  wire logic [hswdr_pkg::RtW-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [hswdr_pkg::ValW-1:0] sample_value_i,
  input  wire logic [hswdr_pkg::TsW-1:0]         timestamp_us_i,
  input  wire logic [hswdr_pkg::DayW-1:0]        day_of_month_i,
  input  wire logic [hswdr_pkg::HourW-1:0]       hour_of_day_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   switch_on_o,
  output logic                                   turned_on_o,
  output logic                                   turned_off_o,
  output logic                                   by_timer_o,
  output logic [hswdr_pkg::RtW-1:0]              runtime_today_us_o
);

  hswdr_pkg::cfg_t  cfg;
  hswdr_pkg::item_t item_q;
  hswdr_pkg::res_t  res_d, res_q;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             advance;
  logic             accept_in;

  hswdr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hswdr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_q),
    .fire_i (advance),
    .res_o  (res_d)
  );

  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    advance     = s1_valid_q && out_free;
    in_stall_o  = s1_valid_q && !out_free;
    accept_in   = in_valid_i && !in_stall_o;
    s1_valid_d  = accept_in || (s1_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      item_q.sample_value <= sample_value_i;
      item_q.timestamp_us <= timestamp_us_i;
      item_q.day_of_month <= day_of_month_i;
      item_q.hour_of_day  <= hour_of_day_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign switch_on_o        = res_q.switch_on;
  assign turned_on_o        = res_q.turned_on;
  assign turned_off_o       = res_q.turned_off;
  assign by_timer_o         = res_q.by_timer;
  assign runtime_today_us_o = res_q.runtime_today_us;

  `HSWDR_ASSERT(a_flags_exclusive, out_valid_o |-> !(turned_on_o && turned_off_o), "turned on and off at once")
  `HSWDR_ASSERT(a_timer_is_turn_on, (out_valid_o && by_timer_o) |-> (turned_on_o && switch_on_o), "timer flag without a switch-on")
  `HSWDR_ASSERT(a_flags_match_state, (out_valid_o && (turned_on_o || turned_off_o)) |-> (switch_on_o == turned_on_o), "switch flags disagree with the output state")
  `HSWDR_ASSERT_ALWAYS(a_stall_only_when_busy, in_stall_o |-> s1_valid_q, "input stalled with an empty input register")

endmodule

`default_nettype wire
